FILE: hw/rtl/stable_sorted_priority_queue_macros.svh
// Assertion macros used by the priority queue top level.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold on every clock edge out of reset.
`define SSP_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("ssp assertion failed");

// Implication: trigger now, consequence on the next edge.
`define SSP_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error("ssp assertion failed");

`else

`define SSP_ASSERT_ALWAYS(lbl, cond)
`define SSP_ASSERT_NEXT(lbl, trig, cons)

`endif

`endif

FILE: hw/rtl/ssp_pkg.sv
// Types, codes and sizes for the stable sorted priority queue.
package ssp_pkg;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int CODE_BITS     = 16;
    localparam int CNT_W         = $clog2(CAPACITY + 1);

    // Input opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CODE_BITS-1:0]     code;
        logic [PRIORITY_BITS-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_slot;

    // What every cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_entry   item;
    } t_cmd;

endpackage

FILE: hw/rtl/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue: control and chain of cells.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready   | opcode, item_code, item_priority
//  out     | output    | o_out_valid / i_out_ready | status, out_code, out_priority, last
//
// Insert and remove act on the whole chain at once: every cell decides locally in the same
// cycle, so one word per cycle is sustained while results are taken.
// A read-out of N entries holds off the input until it is done: the accepted read enters
// the stream state, then N result words follow while the chain rotates once round.
// Reset (synchronous, active low) empties the queue; no clearing pass.
// A stalled output register blocks input and pauses a read-out stream.
`include "stable_sorted_priority_queue_macros.svh"

module stable_sorted_priority_queue
    import ssp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_opcode,
    input  logic [CODE_BITS-1:0]     i_item_code,
    input  logic [PRIORITY_BITS-1:0] i_item_priority,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_status,
    output logic [CODE_BITS-1:0]     o_out_code,
    output logic [PRIORITY_BITS-1:0] o_out_priority,
    output logic                     o_last
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_STREAM = 2'b10
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_remain;
    logic [CNT_W-1:0]     n_remain;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [1:0]           r_status;
    logic [1:0]           n_status;
    t_entry               r_out;
    t_entry               n_out;
    logic                 r_last;
    logic                 n_last;

    t_cmd                 w_cmd;
    t_slot                w_slot      [CAPACITY];
    logic                 w_keep      [CAPACITY];
    logic                 w_prev_keep [CAPACITY];
    t_slot                w_prev      [CAPACITY];
    t_slot                w_next      [CAPACITY];
    logic [CAPACITY-1:0]  w_valid_vec;
    logic [CNT_W-1:0]     w_fill;

    logic                 w_out_free;
    logic                 w_accept;
    logic                 w_empty;
    logic                 w_full;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_empty    = !w_slot[0].valid;
    assign w_full     = w_slot[CAPACITY-1].valid;
    assign w_fill     = CNT_W'($countones(w_valid_vec));

    // neighbour wiring of the chain
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            w_valid_vec[k] = w_slot[k].valid;
            if (k == 0) begin
                w_prev_keep[k] = 1'b1;
                w_prev[k]      = '0;
            end else begin
                w_prev_keep[k] = w_keep[k-1];
                w_prev[k]      = w_slot[k-1];
            end
            if (k == CAPACITY - 1) begin
                w_next[k] = '0;
            end else begin
                w_next[k] = w_slot[k+1];
            end
        end
    end

    // control: command to the chain and the result word
    always_comb begin
        n_state       = r_state;
        n_remain      = r_remain;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_status      = r_status;
        n_out         = r_out;
        n_last        = r_last;
        w_cmd.op      = CELL_HOLD;
        w_cmd.item    = '{code: i_item_code, prio: i_item_priority};
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_opcode)
                        OP_INSERT: begin
                            n_out_valid = 1'b1;
                            n_out       = '0;
                            n_last      = 1'b1;
                            n_status    = w_full ? ST_FULL : ST_OK;
                            if (!w_full) begin
                                w_cmd.op = CELL_INSERT;
                            end
                        end
                        OP_REMOVE: begin
                            n_out_valid = 1'b1;
                            n_last      = 1'b1;
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                                n_out    = '0;
                            end else begin
                                n_status = ST_OK;
                                n_out    = w_slot[0].entry;
                                w_cmd.op = CELL_REMOVE;
                            end
                        end
                        OP_READ: begin
                            if (w_empty) begin
                                n_out_valid = 1'b1;
                                n_status    = ST_EMPTY;
                                n_out       = '0;
                                n_last      = 1'b1;
                            end else begin
                                n_state  = S_STREAM;
                                n_remain = w_fill;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_STREAM: begin
                // emit the front word and rotate it to the rear
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_out       = w_slot[0].entry;
                    n_last      = (r_remain == CNT_W'(1));
                    n_remain    = r_remain - CNT_W'(1);
                    w_cmd.op    = CELL_ROTATE;
                    if (r_remain == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // the chain itself
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ssp_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_prev_keep (w_prev_keep[g]),
            .i_prev      (w_prev[g]),
            .i_next      (w_next[g]),
            .i_front     (w_slot[0].entry),
            .o_slot      (w_slot[g]),
            .o_keep      (w_keep[g])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_out    <= n_out;
        r_last   <= n_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_code     = r_out.code;
    assign o_out_priority = r_out.prio;
    assign o_last         = r_last;

    // occupied cells always form a run from the front
    `SSP_ASSERT_ALWAYS(a_valid_prefix, (w_valid_vec & (w_valid_vec + 1'b1)) == '0)
    // a stream never runs with nothing left to send
    `SSP_ASSERT_ALWAYS(a_stream_count, (r_state != S_STREAM) || (r_remain != '0))
    // input is never taken while a read-out is rotating the chain
    `SSP_ASSERT_ALWAYS(a_ready_idle, !o_in_ready || (r_state == S_IDLE))
    // a remove from a non-empty queue frees exactly one cell
    `SSP_ASSERT_NEXT(a_remove_count, w_accept && (i_opcode == OP_REMOVE) && !w_empty,
                     w_fill == $past(w_fill) - 1'b1)

endmodule

FILE: hw/rtl/ssp_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbours.
module ssp_cell
    import ssp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  logic   i_prev_keep,
    input  t_slot  i_prev,
    input  t_slot  i_next,
    input  t_entry i_front,
    output t_slot  o_slot,
    output logic   o_keep
);

    logic   r_valid;
    t_entry r_entry;
    logic   n_valid;
    t_entry n_entry;

    // entry stays put on insert if it is not later than the new item
    assign o_keep = r_valid && (r_entry.prio <= i_cmd.item.prio);
    assign o_slot = '{valid: r_valid, entry: r_entry};

    // next-state selection
    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (!o_keep) begin
                    if (i_prev_keep) begin
                        n_valid = 1'b1;
                        n_entry = i_cmd.item;
                    end else begin
                        n_valid = i_prev.valid;
                        n_entry = i_prev.entry;
                    end
                end
            end
            CELL_REMOVE: begin
                n_valid = i_next.valid;
                n_entry = i_next.entry;
            end
            CELL_ROTATE: begin
                // rear cell wraps the front round; others shift forward
                if (i_next.valid) begin
                    n_entry = i_next.entry;
                end else if (r_valid) begin
                    n_entry = i_front;
                end
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: tb/tb_stable_sorted_priority_queue.sv
// Self-checking testbench for the stable sorted priority queue.
`timescale 1ns / 100ps

module tb_stable_sorted_priority_queue
    import ssp_pkg::*;
();

    // Opcode value the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic [CODE_BITS-1:0]     code;
        logic [PRIORITY_BITS-1:0] prio;
        logic [3:0]               gap;
    } t_queue_word;

    typedef struct packed {
        logic [1:0]               status;
        logic [CODE_BITS-1:0]     code;
        logic [PRIORITY_BITS-1:0] prio;
        logic                     last;
    } t_queue_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [1:0]               i_opcode = OP_INSERT;
    logic [CODE_BITS-1:0]     i_item_code = '0;
    logic [PRIORITY_BITS-1:0] i_item_priority = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [1:0]               o_status;
    logic [CODE_BITS-1:0]     o_out_code;
    logic [PRIORITY_BITS-1:0] o_out_priority;
    logic                     o_last;

    stable_sorted_priority_queue uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_item_code     (i_item_code),
        .i_item_priority (i_item_priority),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_out_code      (o_out_code),
        .o_out_priority  (o_out_priority),
        .o_last          (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Words waiting to be offered, and results the queue still owes us
    t_queue_word   queued_words[$];
    t_queue_word   offered;
    t_queue_result due_results[$];
    t_queue_result oldest;

    // Shadow copy of the sorted queue contents
    logic [CODE_BITS-1:0]     shadow_code [CAPACITY];
    logic [PRIORITY_BITS-1:0] shadow_prio [CAPACITY];
    int                       shadow_fill = 0;

    bit          calm_sender = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned gap_count = 0;
    int unsigned stall_left = 0;
    int unsigned stall_draw;
    int          words_sent = 0;
    int          results_checked = 0;
    int          mismatches = 0;
    int          full_refusals = 0;
    int          empty_replies = 0;
    int          readouts = 0;
    int          peak_fill = 0;

    task automatic owe_result(input logic [1:0] status, input logic [CODE_BITS-1:0] code,
                              input logic [PRIORITY_BITS-1:0] prio, input logic last);
        t_queue_result r;
        r.status = status;
        r.code   = code;
        r.prio   = prio;
        r.last   = last;
        due_results.push_back(r);
    endtask

    // Apply one accepted word to the shadow queue and list the results it owes
    task automatic apply_queue_op(input t_queue_word w);
        int slot;
        int idx;
        slot = 0;
        case (w.op)
            OP_INSERT: begin
                if (shadow_fill >= CAPACITY) begin
                    owe_result(ST_FULL, '0, '0, 1'b1);
                    full_refusals++;
                end else begin
                    // goes behind every entry of equal or smaller priority
                    while (slot < shadow_fill && shadow_prio[slot] <= w.prio)
                        slot++;
                    for (idx = shadow_fill; idx > slot; idx--) begin
                        shadow_code[idx] = shadow_code[idx-1];
                        shadow_prio[idx] = shadow_prio[idx-1];
                    end
                    shadow_code[slot] = w.code;
                    shadow_prio[slot] = w.prio;
                    shadow_fill++;
                    if (shadow_fill > peak_fill)
                        peak_fill = shadow_fill;
                    owe_result(ST_OK, '0, '0, 1'b1);
                end
            end
            OP_REMOVE: begin
                if (shadow_fill == 0) begin
                    owe_result(ST_EMPTY, '0, '0, 1'b1);
                    empty_replies++;
                end else begin
                    owe_result(ST_OK, shadow_code[0], shadow_prio[0], 1'b1);
                    for (idx = 1; idx < shadow_fill; idx++) begin
                        shadow_code[idx-1] = shadow_code[idx];
                        shadow_prio[idx-1] = shadow_prio[idx];
                    end
                    shadow_fill--;
                end
            end
            OP_READ: begin
                readouts++;
                if (shadow_fill == 0) begin
                    owe_result(ST_EMPTY, '0, '0, 1'b1);
                    empty_replies++;
                end else begin
                    for (idx = 0; idx < shadow_fill; idx++)
                        owe_result(ST_OK, shadow_code[idx], shadow_prio[idx],
                                   idx == shadow_fill - 1);
                end
            end
            default: begin
                // unused opcode: no result, queue untouched
            end
        endcase
    endtask

    task automatic queue_word(input logic [1:0] op, input logic [CODE_BITS-1:0] code,
                              input logic [PRIORITY_BITS-1:0] prio);
        t_queue_word w;
        w.op   = op;
        w.code = code;
        w.prio = prio;
        w.gap  = calm_sender ? 4'd0 : 4'($urandom_range(0, 12));
        queued_words.push_back(w);
    endtask

    // Sender: offers queued words, idling the drawn number of cycles before each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_count  <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                apply_queue_op(offered);
                words_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (queued_words.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (gap_count < queued_words[0].gap) begin
                    gap_count  <= gap_count + 1;
                    i_in_valid <= 1'b0;
                end else begin
                    offered = queued_words.pop_front();
                    i_opcode        <= offered.op;
                    i_item_code     <= offered.code;
                    i_item_priority <= offered.prio;
                    i_in_valid      <= 1'b1;
                    gap_count       <= 0;
                end
            end
        end
    end

    // Receiver: checks each result word and stalls at random, once for a long while
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result word: status %0d code %h prio %h last %b",
                             $time, o_status, o_out_code, o_out_priority, o_last);
                    mismatches++;
                end else begin
                    oldest = due_results.pop_front();
                    if (o_status !== oldest.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, oldest.status, o_status);
                        mismatches++;
                    end
                    if (o_out_code !== oldest.code) begin
                        $display("%0t: code expected %h, got %h",
                                 $time, oldest.code, o_out_code);
                        mismatches++;
                    end
                    if (o_out_priority !== oldest.prio) begin
                        $display("%0t: priority expected %h, got %h",
                                 $time, oldest.prio, o_out_priority);
                        mismatches++;
                    end
                    if (o_last !== oldest.last) begin
                        $display("%0t: last expected %b, got %b",
                                 $time, oldest.last, o_last);
                        mismatches++;
                    end
                end
                results_checked++;
                // long hold-off once, so the queue backs up and stalls its input
                if (!hold_done && results_checked >= 60) begin
                    hold_done = 1'b1;
                    stall_draw = 300;
                end else if ((results_checked / 40) % 3 == 2) begin
                    stall_draw = 0;
                end else begin
                    stall_draw = $urandom_range(0, 12);
                end
                stall_left  <= stall_draw;
                i_out_ready <= (stall_draw == 0);
            end else if (stall_left != 0) begin
                stall_left  <= stall_left - 1;
                i_out_ready <= (stall_left == 1);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        int                       useful;
        int                       mix;
        int unsigned              pick;
        logic [1:0]               op;
        logic [PRIORITY_BITS-1:0] prio;

        // directed: empty cases, ignored opcode, extremes, ties, then fill to full
        queue_word(OP_REMOVE, 16'h1111, 8'h11);
        queue_word(OP_READ, 16'h2222, 8'h22);
        queue_word(OP_UNUSED, 16'hFFFF, 8'hFF);
        queue_word(OP_INSERT, 16'hFFFF, 8'h00);
        queue_word(OP_INSERT, 16'h0000, 8'hFF);
        queue_word(OP_INSERT, 16'hA5A5, 8'h00);
        queue_word(OP_INSERT, 16'h5A5A, 8'h80);
        queue_word(OP_INSERT, 16'h1234, 8'h80);
        queue_word(OP_READ, 16'h0000, 8'h00);
        queue_word(OP_REMOVE, 16'h0000, 8'h00);
        queue_word(OP_UNUSED, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        queue_word(OP_READ, 16'hFFFF, 8'hFF);
        repeat (12)
            queue_word(OP_INSERT, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        queue_word(OP_INSERT, 16'hBEEF, 8'h00);
        queue_word(OP_READ, 16'h0000, 8'h00);

        // random: phases that lean to filling, draining, or neither
        useful = 0;
        while (useful < 185) begin
            mix = (useful / 30) % 3;
            calm_sender = ((useful / 20) % 4 == 3);
            case ($urandom_range(0, 9))
                0:          prio = '0;
                1:          prio = '1;
                2, 3, 4, 5: prio = 8'($urandom_range(0, 3));
                default:    prio = 8'($urandom_range(0, 255));
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 3)
                op = OP_UNUSED;
            else if (pick < 11)
                op = OP_READ;
            else if (pick < (mix == 0 ? 80 : (mix == 1 ? 35 : 56)))
                op = OP_INSERT;
            else
                op = OP_REMOVE;
            queue_word(op, 16'($urandom_range(0, 65535)), prio);
            if (op != OP_UNUSED)
                useful++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_words.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (32) @(posedge i_clk);

        $display("Run covered %0d words in and %0d result words checked, %0d read-outs.",
                 words_sent, results_checked, readouts);
        $display("Queue peaked at %0d of %0d entries; %0d refused as full, %0d empty replies.",
                 peak_fill, CAPACITY, full_refusals, empty_replies);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
